// ----- hw/rtl/sorted_priority_list_assert.svh -----
// Assertion macros used by the sorted priority list sequencer.
`ifndef SORTED_PRIORITY_LIST_ASSERT_SVH
`define SORTED_PRIORITY_LIST_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SPL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_list: same-cycle check failed");

`define SPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_list: next-cycle check failed");

`else

`define SPL_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define SPL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/spl_pkg.sv -----
// Types and constants of the sorted priority list.
`default_nettype none

package spl_pkg;

    localparam int OPCODE_W  = 3;
    localparam int INDEX_W   = 6;
    localparam int PRIO_W    = 8;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 3'd0,
        OP_APPEND = 3'd1,
        OP_REMOVE = 3'd2,
        OP_GET    = 3'd3,
        OP_SET    = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADIDX = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_PLACE,
        S_GET,
        S_CAPTURE,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status                status;
        logic [PRIO_W-1:0]      read_priority;
        logic [PAYLOAD_W-1:0]   read_payload;
        logic [COUNT_W-1:0]     entry_count;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/spl_if.sv -----
// Valid/ready channel interfaces for request and result items.
`default_nettype none

interface spl_in_if;
    import spl_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OPCODE_W-1:0]    opcode;
    logic [INDEX_W-1:0]     index;
    logic [PRIO_W-1:0]      priority_req;
    logic [PAYLOAD_W-1:0]   payload;

    modport source (output valid, opcode, index, priority_req, payload, input ready);
    modport sink (input valid, opcode, index, priority_req, payload, output ready);
endinterface

interface spl_out_if;
    import spl_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [PRIO_W-1:0]      read_priority;
    logic [PAYLOAD_W-1:0]   read_payload;
    logic [COUNT_W-1:0]     entry_count;

    modport source (output valid, status, read_priority, read_payload, entry_count,
                    input ready);
    modport sink (input valid, status, read_priority, read_payload, entry_count,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sorted_priority_list.sv -----
// Top level of the sorted priority list: sequencer, entry memory, result register.
//
//  channel  | port   | direction | item
//  ---------+--------+-----------+-----------------------------------------------
//  request  | i_in   | sink      | opcode, index, priority_req, payload
//  result   | o_out  | source    | status, read_priority, read_payload, entry_count
//
// One item is handled at a time through one write and one read port, one entry a cycle.
// Insert scans for its place, then shifts the later entries up.
// Remove shifts the later entries down; get reads one entry, set and append write one.
// Reset clears the count and the sequencer state; the entry memory needs no clearing pass.
// A result waits in the output register while the next item is accepted.

`default_nettype none

module sorted_priority_list #(
    parameter int CAPACITY     = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spl_in_if.sink     i_in,
    spl_out_if.source  o_out
);

    import spl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int EW = PRIO_W + PAYLOAD_BITS;

    logic           seq_idle;
    logic           seq_start;
    logic           res_vld;
    logic           res_take;
    t_result        res;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [EW-1:0]  mem_wdata;
    logic [AW-1:0]  mem_raddr;
    logic [EW-1:0]  mem_rdata;

    t_result        r_out;
    logic           r_out_vld;

    assign i_in.ready = seq_idle;
    assign seq_start  = i_in.valid && seq_idle;
    assign res_take   = !r_out_vld || o_out.ready;

    spl_seq #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .AW           (AW),
        .EW           (EW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (seq_start),
        .i_opcode   (i_in.opcode),
        .i_index    (i_in.index),
        .i_priority (i_in.priority_req),
        .i_payload  (i_in.payload),
        .o_idle     (seq_idle),
        .i_res_take (res_take),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .o_we       (mem_we),
        .o_waddr    (mem_waddr),
        .o_wdata    (mem_wdata),
        .o_raddr    (mem_raddr),
        .i_rdata    (mem_rdata)
    );

    spl_store #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .EW    (EW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld && res_take) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld && res_take) begin
            r_out <= res;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.status        = r_out.status;
    assign o_out.read_priority = r_out.read_priority;
    assign o_out.read_payload  = r_out.read_payload;
    assign o_out.entry_count   = r_out.entry_count;

endmodule

`default_nettype wire

// ----- hw/rtl/spl_store.sv -----
// Entry memory with one write port and one registered read port.
`default_nettype none

module spl_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int EW    = 40
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [EW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [EW-1:0] o_rdata
);

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/spl_seq.sv -----
// Sequencer that scans, shifts, reads and writes the entry memory.
`default_nettype none

module spl_seq #(
    parameter int CAPACITY     = 64,
    parameter int PAYLOAD_BITS = 32,
    parameter int AW           = 6,
    parameter int EW           = 40
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [spl_pkg::OPCODE_W-1:0]     i_opcode,
    input  wire logic [spl_pkg::INDEX_W-1:0]      i_index,
    input  wire logic [spl_pkg::PRIO_W-1:0]       i_priority,
    input  wire logic [spl_pkg::PAYLOAD_W-1:0]    i_payload,
    output logic                                  o_idle,
    input  wire logic                             i_res_take,
    output logic                                  o_res_vld,
    output spl_pkg::t_result                      o_res,
    output logic                                  o_we,
    output logic      [AW-1:0]                    o_waddr,
    output logic      [EW-1:0]                    o_wdata,
    output logic      [AW-1:0]                    o_raddr,
    input  wire logic [EW-1:0]                    i_rdata
);

    import spl_pkg::*;

    `include "sorted_priority_list_assert.svh"

    localparam int CW = $clog2(CAPACITY + 1);

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic                       r_pend, n_pend;
    logic [OPCODE_W-1:0]        r_op, n_op;
    logic [PRIO_W-1:0]          r_prio, n_prio;
    logic [PAYLOAD_BITS-1:0]    r_pl, n_pl;
    logic [AW-1:0]              r_ptr, n_ptr;
    logic [AW-1:0]              r_wa, n_wa;
    logic [AW-1:0]              r_pos, n_pos;
    logic [CW-1:0]              r_left, n_left;
    logic                       r_dir_up, n_dir_up;
    t_status                    r_status, n_status;
    logic [PRIO_W-1:0]          r_rprio, n_rprio;
    logic [PAYLOAD_W-1:0]       r_rpl, n_rpl;

    logic [PRIO_W-1:0]          rd_prio;
    logic                       idx_bad;

    assign rd_prio = i_rdata[EW-1 -: PRIO_W];
    assign idx_bad = ({{CW{1'b0}}, i_index} >= {{INDEX_W{1'b0}}, r_count});

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pend   = r_pend;
        n_op     = r_op;
        n_prio   = r_prio;
        n_pl     = r_pl;
        n_ptr    = r_ptr;
        n_wa     = r_wa;
        n_pos    = r_pos;
        n_left   = r_left;
        n_dir_up = r_dir_up;
        n_status = r_status;
        n_rprio  = r_rprio;
        n_rpl    = r_rpl;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op     = i_opcode;
                    n_prio   = i_priority;
                    n_pl     = PAYLOAD_BITS'(i_payload);
                    n_rprio  = '0;
                    n_rpl    = '0;
                    n_status = ST_OK;
                    n_pend   = 1'b0;
                    n_dir_up = 1'b1;
                    n_state  = S_DONE;
                    case (i_opcode)
                        OP_INSERT, OP_APPEND: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (i_opcode == OP_APPEND) begin
                                n_pos   = AW'(r_count);
                                n_state = S_PLACE;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_SEARCH;
                            end
                        end
                        OP_REMOVE: begin
                            if (idx_bad) begin
                                n_status = ST_BADIDX;
                            end else begin
                                n_ptr    = AW'(i_index) + AW'(1);
                                n_left   = r_count - CW'(1) - CW'(i_index);
                                n_dir_up = 1'b0;
                                n_state  = S_SHIFT;
                            end
                        end
                        OP_GET: begin
                            if (idx_bad) begin
                                n_status = ST_BADIDX;
                            end else begin
                                n_ptr   = AW'(i_index);
                                n_state = S_GET;
                            end
                        end
                        OP_SET: begin
                            if (idx_bad) begin
                                n_status = ST_BADIDX;
                            end else begin
                                n_pos   = AW'(i_index);
                                n_state = S_PLACE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (r_pend && (rd_prio < r_prio)) begin
                    n_pos   = r_ptr - AW'(1);
                    n_ptr   = AW'(r_count - CW'(1));
                    n_left  = r_count - CW'(r_ptr - AW'(1));
                    n_pend  = 1'b0;
                    n_state = S_SHIFT;
                end else if (CW'(r_ptr) == r_count) begin
                    n_pos   = r_ptr;
                    n_state = S_PLACE;
                end else begin
                    n_ptr  = r_ptr + AW'(1);
                    n_pend = 1'b1;
                end
            end
            S_SHIFT: begin
                if (r_left != '0) begin
                    n_wa   = r_dir_up ? (r_ptr + AW'(1)) : (r_ptr - AW'(1));
                    n_ptr  = r_dir_up ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));
                    n_left = r_left - CW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (r_op == OP_REMOVE) begin
                            n_count = r_count - CW'(1);
                            n_state = S_DONE;
                        end else begin
                            n_state = S_PLACE;
                        end
                    end
                end
            end
            S_PLACE: begin
                if (r_op != OP_SET) begin
                    n_count = r_count + CW'(1);
                end
                n_state = S_DONE;
            end
            S_GET: begin
                n_state = S_CAPTURE;
            end
            S_CAPTURE: begin
                n_rprio = rd_prio;
                n_rpl   = PAYLOAD_W'(i_rdata[PAYLOAD_BITS-1:0]);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_we      = 1'b0;
        o_waddr   = r_wa;
        o_wdata   = i_rdata;
        o_raddr   = r_ptr;
        o_idle    = 1'b0;
        o_res_vld = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_idle = 1'b1;
            end
            S_SHIFT: begin
                o_we = r_pend;
            end
            S_PLACE: begin
                o_we    = 1'b1;
                o_waddr = r_pos;
                o_wdata = {r_prio, r_pl};
            end
            S_DONE: begin
                o_res_vld = 1'b1;
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    assign o_res.status        = r_status;
    assign o_res.read_priority = r_rprio;
    assign o_res.read_payload  = r_rpl;
    assign o_res.entry_count   = COUNT_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_prio   <= n_prio;
        r_pl     <= n_pl;
        r_ptr    <= n_ptr;
        r_wa     <= n_wa;
        r_pos    <= n_pos;
        r_left   <= n_left;
        r_dir_up <= n_dir_up;
        r_status <= n_status;
        r_rprio  <= n_rprio;
        r_rpl    <= n_rpl;
    end

    `SPL_ASSERT_IMPL(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `SPL_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_state != S_IDLE)
    `SPL_ASSERT_IMPL(a_left_bound, i_clk, i_rst_n, r_state == S_SHIFT, r_left <= r_count)
    `SPL_ASSERT_NEXT(a_place_grows, i_clk, i_rst_n, r_state == S_PLACE && r_op != OP_SET,
                     r_count == $past(r_count) + CW'(1))

endmodule

`default_nettype wire

// ----- verif/sorted_priority_list_tb.sv -----
// Testbench for the sorted priority list: directed and random request traffic checked against a shadow list.
`timescale 1ns / 100ps

module sorted_priority_list_tb;
    import spl_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int HOLD_CYCLES = 600;
    localparam int STUCK_LIMIT = 4000;
    localparam int SETTLE_WAIT = 2 * LIST_DEPTH + 20;
    localparam int RANDOM_ITEMS = 927;
    localparam int HOLD_AFTER  = 400;
    localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED, PH_NOISE} t_phase;

    class list_scoreboard;
        logic [PRIO_W-1:0]    prio_q [LIST_DEPTH];
        logic [PAYLOAD_W-1:0] payload_q [LIST_DEPTH];
        int                   held;
        int                   results_seen;
        int                   errors;
        t_result              expected_q [$];

        function new();
            held = 0;
            results_seen = 0;
            errors = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) begin
                $display("ERROR: %s", msg);
            end
        endfunction

        function void note_request(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx,
                                   logic [PRIO_W-1:0] pr, logic [PAYLOAD_W-1:0] pl);
            t_result want;
            int      pos;
            want = '0;
            want.status = ST_OK;
            case (op)
                OP_INSERT, OP_APPEND: begin
                    if (held == LIST_DEPTH) begin
                        want.status = ST_FULL;
                    end else begin
                        pos = held;
                        if (op == OP_INSERT) begin
                            for (int i = held - 1; i >= 0; i--) begin
                                if (prio_q[i] < pr) pos = i;
                            end
                        end
                        for (int i = held; i > pos; i--) begin
                            prio_q[i] = prio_q[i-1];
                            payload_q[i] = payload_q[i-1];
                        end
                        prio_q[pos] = pr;
                        payload_q[pos] = pl;
                        held++;
                    end
                end
                OP_REMOVE, OP_GET, OP_SET: begin
                    if (int'(idx) >= held) begin
                        want.status = ST_BADIDX;
                    end else if (op == OP_REMOVE) begin
                        for (int i = idx; i + 1 < held; i++) begin
                            prio_q[i] = prio_q[i+1];
                            payload_q[i] = payload_q[i+1];
                        end
                        held--;
                    end else if (op == OP_GET) begin
                        want.read_priority = prio_q[idx];
                        want.read_payload = payload_q[idx];
                    end else begin
                        prio_q[idx] = pr;
                        payload_q[idx] = pl;
                    end
                end
                default: ;
            endcase
            want.entry_count = COUNT_W'(held);
            expected_q.push_back(want);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [PRIO_W-1:0] rp,
                                   logic [PAYLOAD_W-1:0] rd, logic [COUNT_W-1:0] cnt);
            t_result want;
            results_seen++;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected result %0d: status=%0d prio=%02h payload=%08h count=%0d",
                               results_seen, st, rp, rd, cnt));
            end else begin
                want = expected_q.pop_front();
                if (st !== want.status || rp !== want.read_priority ||
                    rd !== want.read_payload || cnt !== want.entry_count) begin
                    flag($sformatf({"result %0d: expected status=%0d prio=%02h payload=%08h ",
                                    "count=%0d, got status=%0d prio=%02h payload=%08h count=%0d"},
                                   results_seen, want.status, want.read_priority,
                                   want.read_payload, want.entry_count, st, rp, rd, cnt));
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic hold_off;
    int   accepted;
    int   burst_left;
    int   stuck_cycles;

    list_scoreboard sb;

    spl_in_if  in_ch ();
    spl_out_if out_ch ();

    sorted_priority_list #(
        .CAPACITY     (LIST_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_W)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_item(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx,
                             logic [PRIO_W-1:0] pr, logic [PAYLOAD_W-1:0] pl);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= op;
        in_ch.index        <= idx;
        in_ch.priority_req <= pr;
        in_ch.payload      <= pl;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_request(op, idx, pr, pl);
        accepted++;
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        burst_left = 0;
    endtask

    function automatic logic [OPCODE_W-1:0] choose_op(t_phase ph, int r);
        int w_ins, w_app, w_rem, w_get, w_set;
        case (ph)
            PH_GROW: begin
                w_ins = 45; w_app = 20; w_rem = 10; w_get = 15; w_set = 5;
            end
            PH_SHRINK: begin
                w_ins = 10; w_app = 5; w_rem = 50; w_get = 20; w_set = 10;
            end
            default: begin
                w_ins = 25; w_app = 10; w_rem = 20; w_get = 25; w_set = 15;
            end
        endcase
        if (r < w_ins) return OP_INSERT;
        if (r < w_ins + w_app) return OP_APPEND;
        if (r < w_ins + w_app + w_rem) return OP_REMOVE;
        if (r < w_ins + w_app + w_rem + w_get) return OP_GET;
        if (r < w_ins + w_app + w_rem + w_get + w_set) return OP_SET;
        return OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    endfunction

    task automatic run_directed();
        send_item(OP_GET, '0, '0, '0);
        send_item(OP_REMOVE, '1, '0, '0);
        send_item(OP_SET, '0, 8'h55, 32'h1234_5678);
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
            send_item(OPCODE_W'(op), '1, '1, '1);
        end
        send_item(OP_INSERT, '0, 8'h80, 32'hFFFF_FFFF);
        send_item(OP_INSERT, '1, 8'hFF, 32'h0000_0000);
        send_item(OP_INSERT, '0, 8'h00, 32'h0000_0001);
        send_item(OP_INSERT, '0, 8'h80, 32'h0000_0002);
        send_item(OP_APPEND, '0, 8'hFF, 32'h0000_0003);
        send_item(OP_SET, '0, 8'h00, 32'hA5A5_A5A5);
        send_item(OP_INSERT, '0, 8'h7F, 32'h0000_0004);
        for (int i = 0; i <= 6; i++) begin
            send_item(OP_GET, INDEX_W'(i), '0, '0);
        end
        send_item(OP_REMOVE, 6'd5, '0, '0);
        send_item(OP_REMOVE, '0, '0, '0);
        send_item(OP_GET, '1, '1, '1);
    endtask

    task automatic run_random(int total);
        int                   sent;
        int                   span;
        t_phase               ph;
        logic [OPCODE_W-1:0]  op;
        logic [INDEX_W-1:0]   idx;
        logic [PRIO_W-1:0]    pr;
        sent = 0;
        ph = PH_GROW;
        span = 120;
        while (sent < total) begin
            for (int k = 0; k < span && sent < total; k++) begin
                if (ph == PH_NOISE) begin
                    op = OPCODE_W'($urandom_range(0, 7));
                end else begin
                    op = choose_op(ph, $urandom_range(0, 99));
                end
                if ((op == OP_REMOVE || op == OP_GET || op == OP_SET) && ph != PH_NOISE) begin
                    if (sb.held > 0 && $urandom_range(0, 99) < 85) begin
                        idx = INDEX_W'($urandom_range(0, sb.held - 1));
                    end else if (sb.held < LIST_DEPTH) begin
                        idx = INDEX_W'($urandom_range(sb.held, LIST_DEPTH - 1));
                    end else begin
                        idx = INDEX_W'($urandom());
                    end
                end else begin
                    idx = INDEX_W'($urandom());
                end
                if ($urandom_range(0, 9) < 4) begin
                    pr = PRIO_W'($urandom_range(0, 3) * 85);
                end else begin
                    pr = PRIO_W'($urandom_range(0, 255));
                end
                send_item(op, idx, pr, $urandom());
                sent++;
            end
            ph = t_phase'($urandom_range(0, 3));
            span = $urandom_range(10, 80);
            if ($urandom_range(0, 7) == 0) begin
                wait_for_results();
            end
        end
    endtask

    always @(posedge clk) begin
        int        window_left;
        int        stall_mode;
        logic [7:0] pat;
        logic      take;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result(out_ch.status, out_ch.read_priority, out_ch.read_payload,
                            out_ch.entry_count);
        end
        if (window_left <= 0) begin
            window_left = $urandom_range(20, 200);
            stall_mode = $urandom_range(0, 3);
            pat = 8'($urandom());
        end
        window_left--;
        case (stall_mode)
            0: take = 1'b1;
            1: take = 1'($urandom_range(0, 1));
            2: take = ($urandom_range(0, 3) == 0);
            default: begin
                take = pat[0];
                pat = {pat[0], pat[7:1]};
            end
        endcase
        out_ch.ready <= hold_off ? 1'b0 : take;
    end

    initial begin
        hold_off = 1'b0;
        wait (accepted >= HOLD_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("sorted_priority_list_tb: errors");
            $finish;
        end
    end

    initial begin
        sb = new();
        accepted = 0;
        burst_left = 0;
        stuck_cycles = 0;
        in_ch.valid = 1'b0;
        in_ch.opcode = '0;
        in_ch.index = '0;
        in_ch.priority_req = '0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        wait_for_results();
        run_random(RANDOM_ITEMS);
        wait_for_results();
        repeat (SETTLE_WAIT) @(posedge clk);
        if (sb.expected_q.size() != 0) begin
            sb.flag($sformatf("%0d results never arrived", sb.expected_q.size()));
        end
        if (sb.errors == 0) begin
            $display("sorted_priority_list_tb: clean");
        end else begin
            $display("sorted_priority_list_tb: errors");
        end
        $finish;
    end

endmodule
